FILE: rtl/core/awme_pkg.sv
`timescale 1ns / 1ps

package awme_pkg;

  // Sizes of the store and of one GD/PD block
  localparam int MEM_WORDS   = 100;
  localparam int BLOCK_WORDS = 10;

  localparam int ADDR_W = 7;
  localparam int WORD_W = 32;
  localparam int MEM_AW = $clog2(MEM_WORDS);
  localparam int CNT_W  = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;

  localparam logic [ADDR_W-1:0] MEM_LIM = ADDR_W'(MEM_WORDS);
  localparam logic [ADDR_W-1:0] BLK_LIM = ADDR_W'(MEM_WORDS - BLOCK_WORDS);
  localparam logic [CNT_W-1:0]  CNT_END = CNT_W'(BLOCK_WORDS - 1);

  localparam logic [WORD_W-1:0] SPACES = 32'h2020_2020;

  // ASCII codes
  localparam logic [7:0] CH_0 = 8'd48;
  localparam logic [7:0] CH_9 = 8'd57;
  localparam logic [7:0] CH_G = 8'h47;
  localparam logic [7:0] CH_D = 8'h44;
  localparam logic [7:0] CH_P = 8'h50;
  localparam logic [7:0] CH_H = 8'h48;
  localparam logic [7:0] CH_L = 8'h4C;
  localparam logic [7:0] CH_R = 8'h52;
  localparam logic [7:0] CH_S = 8'h53;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_B = 8'h42;
  localparam logic [7:0] CH_T = 8'h54;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_WRITE = 2'd1,
    OP_STEP  = 2'd2,
    OP_RSVD  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_DONE = 3'd0,
    ST_GET  = 3'd1,
    ST_PUT  = 3'd2,
    ST_HALT = 3'd3,
    ST_BAD  = 3'd4,
    ST_IGN  = 3'd5
  } status_t;

  // Microprogram addresses
  typedef enum logic [3:0] {
    UPC_IDLE   = 4'd0,
    UPC_INIT   = 4'd1,
    UPC_WRITE  = 4'd2,
    UPC_IGNORE = 4'd3,
    UPC_FETCH  = 4'd4,
    UPC_LOADIR = 4'd5,
    UPC_DECODE = 4'd6,
    UPC_MEMOP  = 4'd7,
    UPC_PDOUT  = 4'd8
  } upc_t;

  // Datapath operation of one micro step
  typedef enum logic [3:0] {
    UOP_WAIT,
    UOP_INIT,
    UOP_WRITE,
    UOP_IGNORE,
    UOP_FETCH,
    UOP_LDIR,
    UOP_DECODE,
    UOP_MEMOP,
    UOP_PUT
  } uop_t;

  typedef struct packed {
    uop_t op;
    upc_t nxt;   // sequential successor
    upc_t jmp;   // conditional jump target
  } ctrl_word_t;

  function automatic ctrl_word_t ucode_rom(upc_t upc);
    ctrl_word_t cw;
    unique case (upc)
      UPC_IDLE:   cw = '{op: UOP_WAIT,   nxt: UPC_IDLE,   jmp: UPC_IDLE};
      UPC_INIT:   cw = '{op: UOP_INIT,   nxt: UPC_IDLE,   jmp: UPC_IDLE};
      UPC_WRITE:  cw = '{op: UOP_WRITE,  nxt: UPC_IDLE,   jmp: UPC_IDLE};
      UPC_IGNORE: cw = '{op: UOP_IGNORE, nxt: UPC_IDLE,   jmp: UPC_IDLE};
      UPC_FETCH:  cw = '{op: UOP_FETCH,  nxt: UPC_LOADIR, jmp: UPC_IDLE};
      UPC_LOADIR: cw = '{op: UOP_LDIR,   nxt: UPC_DECODE, jmp: UPC_IDLE};
      UPC_DECODE: cw = '{op: UOP_DECODE, nxt: UPC_PDOUT,  jmp: UPC_MEMOP};
      UPC_MEMOP:  cw = '{op: UOP_MEMOP,  nxt: UPC_IDLE,   jmp: UPC_IDLE};
      UPC_PDOUT:  cw = '{op: UOP_PUT,    nxt: UPC_IDLE,   jmp: UPC_PDOUT};
      default:    cw = '{op: UOP_WAIT,   nxt: UPC_IDLE,   jmp: UPC_IDLE};
    endcase
    return cw;
  endfunction

  // Dispatch table: entry step for each host command
  function automatic upc_t entry_of(opcode_t op);
    upc_t upc;
    unique case (op)
      OP_INIT:  upc = UPC_INIT;
      OP_WRITE: upc = UPC_WRITE;
      OP_STEP:  upc = UPC_FETCH;
      OP_RSVD:  upc = UPC_IGNORE;
      default:  upc = UPC_IGNORE;
    endcase
    return upc;
  endfunction

endpackage

FILE: rtl/core/ascii_word_machine_executor_top.sv
`timescale 1ns / 1ps

// Word machine executor: 100 words of four ASCII characters, stepped by a host.
// Input channel: in_opcode/in_address/in_word_in, transfer when start is high
// and busy is low. Commands: init job, write one word, step one instruction.
// Result channel: out_valid strobes one result per cycle with out_status,
// out_address_out, out_word_out and out_last. The receiver cannot stall:
// every strobed result is taken in its cycle.
// Sequence, from the accepting edge to the result strobe:
//   init, write, ignored command: their own micro step, then the result register.
//   step that stops early (halted, counter past memory): fetch, then the result.
//   step: fetch, load IR, decode; LR and CR add a memory step (one more
//   memory read); PD streams its 10 words on consecutive cycles after
//   decode. One item at a time: busy drops with the last result, and the
//   next transfer can occur while that result is on the ports.
// Control is a microprogram (step counter and ROM control words) over one
// memory with one read port and one write port; the read port sets the PD rate.
// Reset (rst_n low, synchronous) and the init command both make every word
// read as spaces through per-word valid bits, so no clearing pass is needed.
module ascii_word_machine_executor_top
  import awme_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_opcode,
  input  logic [ADDR_W-1:0]   in_address,
  input  logic [WORD_W-1:0]   in_word_in,
  output logic                out_valid,
  output logic [2:0]          out_status,
  output logic [ADDR_W-1:0]   out_address_out,
  output logic [WORD_W-1:0]   out_word_out,
  output logic                out_last
);

  // Sequencer
  upc_t       upc_r, upc_nxt;
  ctrl_word_t cw;

  // Latched command
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [WORD_W-1:0] wdata_r, wdata_nxt;

  // Machine registers
  logic [WORD_W-1:0] ir_r, ir_nxt;
  logic [WORD_W-1:0] gp_r, gp_nxt;
  logic [ADDR_W-1:0] ic_r, ic_nxt;
  logic              tog_r, tog_nxt;
  logic              halt_r, halt_nxt;

  // PD block walk
  logic [ADDR_W-1:0] pd_addr_r, pd_addr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  // Result register
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [ADDR_W-1:0] out_addr_r, out_addr_nxt;
  logic [WORD_W-1:0] out_word_r, out_word_nxt;
  logic              out_last_r, out_last_nxt;

  // Memory port
  logic [WORD_W-1:0] mem [MEM_WORDS];
  logic              valid_r [MEM_WORDS];
  logic              mem_we, mem_re, valid_clr;
  logic [MEM_AW-1:0] mem_wa, mem_ra;
  logic [WORD_W-1:0] mem_wd;
  logic [WORD_W-1:0] rdata_r;
  logic              rvalid_r;
  logic [WORD_W-1:0] rword;

  // Instruction decode
  logic [7:0]        c0, c1, hi_ch, lo_ch;
  logic              digits_ok;
  logic [ADDR_W-1:0] dec_a;
  logic              is_gd, is_pd, is_h, is_rr, is_bt;

  assign cw    = ucode_rom(upc_r);
  assign rword = rvalid_r ? rdata_r : SPACES;

  assign c0    = ir_r[31:24];
  assign c1    = ir_r[23:16];
  assign hi_ch = ir_r[15:8];
  assign lo_ch = ir_r[7:0];

  assign digits_ok = (hi_ch >= CH_0) && (hi_ch <= CH_9) &&
                     (lo_ch >= CH_0) && (lo_ch <= CH_9);
  // tens * 10 + units, with the multiply by ten as two shifts
  assign dec_a = ADDR_W'({hi_ch[3:0], 3'b000}) + ADDR_W'({hi_ch[3:0], 1'b0})
               + ADDR_W'(lo_ch[3:0]);

  assign is_gd = (c0 == CH_G) && (c1 == CH_D);
  assign is_pd = (c0 == CH_P) && (c1 == CH_D);
  assign is_h  = (c0 == CH_H);
  assign is_rr = (c1 == CH_R) && ((c0 == CH_L) || (c0 == CH_S) || (c0 == CH_C));
  assign is_bt = (c0 == CH_B) && (c1 == CH_T);

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= UPC_IDLE;
      ic_r        <= '0;
      tog_r       <= 1'b0;
      halt_r      <= 1'b0;
      ir_r        <= SPACES;
      gp_r        <= SPACES;
      out_valid_r <= 1'b0;
    end else begin
      upc_r       <= upc_nxt;
      ic_r        <= ic_nxt;
      tog_r       <= tog_nxt;
      halt_r      <= halt_nxt;
      ir_r        <= ir_nxt;
      gp_r        <= gp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    addr_r       <= addr_nxt;
    wdata_r      <= wdata_nxt;
    pd_addr_r    <= pd_addr_nxt;
    cnt_r        <= cnt_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_word_r   <= out_word_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Word store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_r  <= mem[mem_ra];
      rvalid_r <= valid_r[mem_ra];
    end
  end

  // A word reads as spaces until written after reset or init
  always_ff @(posedge clk) begin
    if (!rst_n || valid_clr) begin
      for (int i = 0; i < MEM_WORDS; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else if (mem_we) begin
      valid_r[mem_wa] <= 1'b1;
    end
  end

  // Next step and datapath control
  always_comb begin
    upc_nxt        = upc_r;
    addr_nxt       = addr_r;
    wdata_nxt      = wdata_r;
    ir_nxt         = ir_r;
    gp_nxt         = gp_r;
    ic_nxt         = ic_r;
    tog_nxt        = tog_r;
    halt_nxt       = halt_r;
    pd_addr_nxt    = pd_addr_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = ST_DONE;
    out_addr_nxt   = '0;
    out_word_nxt   = '0;
    out_last_nxt   = 1'b1;
    mem_we         = 1'b0;
    mem_wa         = '0;
    mem_wd         = '0;
    mem_re         = 1'b0;
    mem_ra         = '0;
    valid_clr      = 1'b0;

    unique case (cw.op)
      UOP_WAIT: begin
        if (start) begin
          addr_nxt  = in_address;
          wdata_nxt = in_word_in;
          upc_nxt   = entry_of(opcode_t'(in_opcode));
        end
      end

      UOP_INIT: begin
        valid_clr     = 1'b1;
        ir_nxt        = SPACES;
        gp_nxt        = SPACES;
        ic_nxt        = '0;
        tog_nxt       = 1'b0;
        halt_nxt      = 1'b0;
        out_valid_nxt = 1'b1;
        upc_nxt       = cw.nxt;
      end

      UOP_WRITE: begin
        out_valid_nxt = 1'b1;
        if (addr_r >= MEM_LIM) begin
          out_status_nxt = ST_BAD;
        end else begin
          mem_we = 1'b1;
          mem_wa = addr_r[MEM_AW-1:0];
          mem_wd = wdata_r;
        end
        upc_nxt = cw.nxt;
      end

      UOP_IGNORE: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_IGN;
        upc_nxt        = cw.nxt;
      end

      UOP_FETCH: begin
        priority if (halt_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_IGN;
          upc_nxt        = cw.jmp;
        end else if (ic_r >= MEM_LIM) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_BAD;
          upc_nxt        = cw.jmp;
        end else begin
          mem_re  = 1'b1;
          mem_ra  = ic_r[MEM_AW-1:0];
          ic_nxt  = ic_r + 1'b1;
          upc_nxt = cw.nxt;
        end
      end

      UOP_LDIR: begin
        ir_nxt  = rword;
        upc_nxt = cw.nxt;
      end

      UOP_DECODE: begin
        out_valid_nxt = 1'b1;
        upc_nxt       = UPC_IDLE;
        priority if (is_gd || is_pd) begin
          if (!digits_ok || (dec_a > BLK_LIM)) begin
            out_status_nxt = ST_BAD;
          end else if (is_gd) begin
            out_status_nxt = ST_GET;
            out_addr_nxt   = dec_a;
          end else begin
            // stream starts next step; first word read now
            out_valid_nxt = 1'b0;
            mem_re        = 1'b1;
            mem_ra        = dec_a[MEM_AW-1:0];
            pd_addr_nxt   = dec_a;
            cnt_nxt       = '0;
            upc_nxt       = cw.nxt;
          end
        end else if (is_h) begin
          halt_nxt       = 1'b1;
          out_status_nxt = ST_HALT;
        end else if (is_rr) begin
          if (!digits_ok || (dec_a >= MEM_LIM)) begin
            out_status_nxt = ST_BAD;
          end else if (c0 == CH_S) begin
            mem_we = 1'b1;
            mem_wa = dec_a[MEM_AW-1:0];
            mem_wd = gp_r;
          end else begin
            out_valid_nxt = 1'b0;
            mem_re        = 1'b1;
            mem_ra        = dec_a[MEM_AW-1:0];
            upc_nxt       = cw.jmp;
          end
        end else if (is_bt && tog_r) begin
          if (!digits_ok || (dec_a >= MEM_LIM)) begin
            out_status_nxt = ST_BAD;
          end else begin
            ic_nxt = dec_a;
          end
        end else begin
          out_status_nxt = ST_DONE;
        end
      end

      UOP_MEMOP: begin
        if (c0 == CH_L) begin
          gp_nxt = rword;
        end else begin
          tog_nxt = (rword == gp_r);
        end
        out_valid_nxt = 1'b1;
        upc_nxt       = cw.nxt;
      end

      UOP_PUT: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_PUT;
        out_addr_nxt   = pd_addr_r;
        out_word_nxt   = rword;
        out_last_nxt   = (cnt_r == CNT_END);
        if (cnt_r == CNT_END) begin
          upc_nxt = cw.nxt;
        end else begin
          mem_re      = 1'b1;
          mem_ra      = MEM_AW'(pd_addr_r + 1'b1);
          pd_addr_nxt = pd_addr_r + 1'b1;
          cnt_nxt     = cnt_r + 1'b1;
          upc_nxt     = cw.jmp;
        end
      end

      default: begin
        upc_nxt = UPC_IDLE;
      end
    endcase
  end

  assign busy            = (upc_r != UPC_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_address_out = out_addr_r;
  assign out_word_out    = out_word_r;
  assign out_last        = out_last_r;

  // A PD stream has no gaps
  a_pd_stream: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid && (out_status == ST_PUT))
    else $error("PD stream broken");

  // Only PD words can be non-final
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_PUT) |-> out_last)
    else $error("non-PD result without last");

  // The sequencer returns to idle only with the final result
  a_idle_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid && out_last)
    else $error("busy dropped without final result");

  // A transfer always starts the sequencer
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("transfer did not start work");

endmodule

FILE: test/ascii_word_machine_executor_top_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the word machine executor.
// A task issues one command per transfer (start high, busy low); a predictor of the
// machine, kept in step with every accepted transfer, queues the results it expects.
// A checker pops that queue on every out_valid strobe and compares all four fields.
module ascii_word_machine_executor_top_tb;
  import awme_pkg::*;

  localparam int STALL_LIMIT = 2000;  // cycles with no transfer on either side
  localparam int MAX_SHOWN   = 10;

  typedef struct {
    status_t            status;
    logic [ADDR_W-1:0]  addr;
    logic [WORD_W-1:0]  word;
    logic               last;
  } result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_opcode = OP_INIT;
  logic [ADDR_W-1:0]  in_address = '0;
  logic [WORD_W-1:0]  in_word_in = '0;
  logic               out_valid;
  logic [2:0]         out_status;
  logic [ADDR_W-1:0]  out_address_out;
  logic [WORD_W-1:0]  out_word_out;
  logic               out_last;

  ascii_word_machine_executor_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_address      (in_address),
    .in_word_in      (in_word_in),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_address_out (out_address_out),
    .out_word_out    (out_word_out),
    .out_last        (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predicted machine state
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0] pm_mem [0:MEM_WORDS-1];
  logic [WORD_W-1:0] pm_gp;
  logic [ADDR_W-1:0] pm_ic;
  logic              pm_toggle;
  logic              pm_halted;
  int                pm_get_base;   // base of the GD request of the last command, -1 if none

  result_t want_q[$];

  int errors = 0;
  int n_sent = 0;
  int n_results = 0;
  int n_put = 0;
  int n_get = 0;
  int n_halt = 0;
  int n_bad = 0;
  int sender_idle_pct = 0;

  function automatic void clear_machine();
    for (int i = 0; i < MEM_WORDS; i++) pm_mem[i] = SPACES;
    pm_gp = SPACES;
    pm_ic = '0;
    pm_toggle = 1'b0;
    pm_halted = 1'b0;
  endfunction

  function automatic void push_result(status_t s, int a, logic [WORD_W-1:0] w, logic l);
    result_t r;
    r.status = s;
    r.addr   = ADDR_W'(a);
    r.word   = w;
    r.last   = l;
    want_q.push_back(r);
  endfunction

  // Two decimal digits in the low half of an instruction, -1 if either is not a digit
  function automatic int digit_addr(logic [WORD_W-1:0] w);
    logic [7:0] hi, lo;
    hi = w[15:8];
    lo = w[7:0];
    if (hi < CH_0 || hi > CH_9 || lo < CH_0 || lo > CH_9) return -1;
    return (int'(hi) - int'(CH_0)) * 10 + (int'(lo) - int'(CH_0));
  endfunction

  // Advance the predicted machine by one accepted command and queue its results
  function automatic void model_cmd(opcode_t op, logic [ADDR_W-1:0] addr,
                                    logic [WORD_W-1:0] word);
    logic [WORD_W-1:0] ir;
    logic [7:0]        c0, c1;
    int                a;
    pm_get_base = -1;
    case (op)
      OP_INIT: begin
        clear_machine();
        push_result(ST_DONE, 0, '0, 1'b1);
      end
      OP_WRITE: begin
        if (addr >= MEM_WORDS) begin
          push_result(ST_BAD, 0, '0, 1'b1);
        end else begin
          pm_mem[addr] = word;
          push_result(ST_DONE, 0, '0, 1'b1);
        end
      end
      OP_STEP: begin
        if (pm_halted) begin
          push_result(ST_IGN, 0, '0, 1'b1);
          return;
        end
        if (pm_ic >= MEM_WORDS) begin
          push_result(ST_BAD, 0, '0, 1'b1);
          return;
        end
        ir = pm_mem[pm_ic];
        pm_ic = pm_ic + 1'b1;
        c0 = ir[31:24];
        c1 = ir[23:16];
        if ((c0 == CH_G || c0 == CH_P) && c1 == CH_D) begin
          a = digit_addr(ir);
          if (a < 0 || a + BLOCK_WORDS > MEM_WORDS) begin
            push_result(ST_BAD, 0, '0, 1'b1);
          end else if (c0 == CH_G) begin
            pm_get_base = a;
            push_result(ST_GET, a, '0, 1'b1);
          end else begin
            for (int i = 0; i < BLOCK_WORDS; i++)
              push_result(ST_PUT, a + i, pm_mem[a + i], i == BLOCK_WORDS - 1);
          end
        end else if (c0 == CH_H) begin
          pm_halted = 1'b1;
          push_result(ST_HALT, 0, '0, 1'b1);
        end else if (c1 == CH_R && (c0 == CH_L || c0 == CH_S || c0 == CH_C)) begin
          a = digit_addr(ir);
          if (a < 0 || a >= MEM_WORDS) begin
            push_result(ST_BAD, 0, '0, 1'b1);
          end else begin
            if (c0 == CH_L) pm_gp = pm_mem[a];
            else if (c0 == CH_S) pm_mem[a] = pm_gp;
            else pm_toggle = (pm_mem[a] == pm_gp);
            push_result(ST_DONE, 0, '0, 1'b1);
          end
        end else if (c0 == CH_B && c1 == CH_T && pm_toggle) begin
          a = digit_addr(ir);
          if (a < 0 || a >= MEM_WORDS) begin
            push_result(ST_BAD, 0, '0, 1'b1);
          end else begin
            pm_ic = ADDR_W'(a);
            push_result(ST_DONE, 0, '0, 1'b1);
          end
        end else begin
          // unknown code or BT with toggle clear
          push_result(ST_DONE, 0, '0, 1'b1);
        end
      end
      default: push_result(ST_IGN, 0, '0, 1'b1);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Command side
  // ---------------------------------------------------------------------------

  // One command transfer. start is left high unless the sender decides to idle,
  // so back-to-back commands never lower and raise start in one step.
  task automatic issue_cmd(opcode_t op, logic [ADDR_W-1:0] addr, logic [WORD_W-1:0] word);
    start      <= 1'b1;
    in_opcode  <= op;
    in_address <= addr;
    in_word_in <= word;
    @(posedge clk);
    while (busy) @(posedge clk);
    model_cmd(op, addr, word);
    n_sent++;
    if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Hold off the sender until every queued result has come back
  task automatic wait_all_results();
    start <= 1'b0;
    while (want_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Random instruction: mostly known codes with a two-digit address, some of
  // them out of range or with a non-digit, often one next to the digit range.
  function automatic logic [WORD_W-1:0] rand_instr();
    int          k, r, a;
    logic [7:0]  c0, c1, nd;
    logic [15:0] tail;
    k = $urandom_range(0, 99);
    r = $urandom_range(0, 9);
    if (k < 12)      {c0, c1} = {CH_G, CH_D};
    else if (k < 28) {c0, c1} = {CH_P, CH_D};
    else if (k < 42) {c0, c1} = {CH_L, CH_R};
    else if (k < 55) {c0, c1} = {CH_S, CH_R};
    else if (k < 70) {c0, c1} = {CH_C, CH_R};
    else if (k < 85) {c0, c1} = {CH_B, CH_T};
    else if (k < 89) {c0, c1} = {CH_H, 8'($urandom)};
    else if (k < 95) {c0, c1} = 16'($urandom);
    else return $urandom;
    a = (k < 28) ? $urandom_range(0, MEM_WORDS - BLOCK_WORDS) : $urandom_range(0, MEM_WORDS - 1);
    if (r < 2) a = $urandom_range(85, 99);
    tail = {8'(CH_0 + a / 10), 8'(CH_0 + a % 10)};
    if (r == 9) begin
      case ($urandom_range(0, 2))
        0: nd = CH_0 - 8'd1;
        1: nd = CH_9 + 8'd1;
        default: begin
          nd = 8'($urandom);
          if (nd >= CH_0 && nd <= CH_9) nd = nd ^ 8'h40;
        end
      endcase
      if ($urandom_range(0, 1)) tail[15:8] = nd;
      else tail[7:0] = nd;
    end
    return {c0, c1, tail};
  endfunction

  // Host data for a GD block; copies of gp and spaces make CR hits likely
  function automatic logic [WORD_W-1:0] data_word();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return SPACES;
      2: return pm_gp;
      default: return rand_instr();
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Fresh machine: blank fetch, write address bounds, reserved opcode
  task automatic test_reset_and_bounds();
    issue_cmd(OP_STEP, 7'd0, 32'h0);
    issue_cmd(OP_WRITE, 7'd127, 32'hFFFF_FFFF);
    issue_cmd(OP_WRITE, 7'd100, 32'h1234_5678);
    issue_cmd(OP_RSVD, 7'd127, 32'hFFFF_FFFF);
  endtask

  // Straight-line program from IC 1: GD, PD of the top block, LR/CR hit, BT
  // taken to 98, BT with a non-digit address, SR at 99, then the counter is past memory.
  task automatic test_block_program();
    issue_cmd(OP_WRITE, 7'd20, 32'hFFFF_FFFF);
    issue_cmd(OP_WRITE, 7'd97, 32'h0000_0000);
    issue_cmd(OP_WRITE, 7'd98, "BT/9");
    issue_cmd(OP_WRITE, 7'd99, "SR00");
    issue_cmd(OP_WRITE, 7'd1, "GD20");
    issue_cmd(OP_WRITE, 7'd2, "PD90");
    issue_cmd(OP_WRITE, 7'd3, "LR20");
    issue_cmd(OP_WRITE, 7'd4, "CR20");
    issue_cmd(OP_WRITE, 7'd5, "BT98");
    repeat (8) issue_cmd(OP_STEP, 7'd127, 32'hFFFF_FFFF);
  endtask

  // Init, PD one past the last full block, halt, step while halted
  task automatic test_halt_and_init();
    issue_cmd(OP_INIT, 7'd127, 32'hFFFF_FFFF);
    issue_cmd(OP_WRITE, 7'd0, "PD91");
    issue_cmd(OP_WRITE, 7'd1, "H0:9");
    repeat (3) issue_cmd(OP_STEP, 7'd0, 32'h0);
  endtask

  // Random jobs: mostly write-at-IC then step, GD answered by a (sometimes
  // short) data block, init after a halt or a run past memory, some noise.
  task automatic test_random_jobs(int items);
    int first, r, n, base;
    first = n_sent;
    while (n_sent - first < items) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        issue_cmd(opcode_t'($urandom_range(0, 3)), 7'($urandom), $urandom);
      end else if (r < 10 || pm_halted || pm_ic >= MEM_WORDS) begin
        if ($urandom_range(0, 1)) issue_cmd(OP_STEP, 7'($urandom), $urandom);
        issue_cmd(OP_INIT, 7'($urandom), $urandom);
      end else begin
        if ($urandom_range(0, 4) != 0) issue_cmd(OP_WRITE, pm_ic, rand_instr());
        issue_cmd(OP_STEP, 7'($urandom), $urandom);
        if (pm_get_base >= 0) begin
          base = pm_get_base;
          n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, BLOCK_WORDS - 1) : BLOCK_WORDS;
          for (int i = 0; i < n; i++) issue_cmd(OP_WRITE, 7'(base + i), data_word());
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every strobe is one transfer, compared with the oldest entry
  // ---------------------------------------------------------------------------
  task automatic log_error(string what);
    errors++;
    if (errors <= MAX_SHOWN) $display("%0t ERROR %s", $time, what);
  endtask

  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_valid) begin
      n_results++;
      case (out_status)
        ST_PUT:  n_put++;
        ST_GET:  n_get++;
        ST_HALT: n_halt++;
        ST_BAD:  n_bad++;
        default: ;
      endcase
      if (want_q.size() == 0) begin
        log_error($sformatf("unexpected result status %0d addr %0d word %h last %0b",
                            out_status, out_address_out, out_word_out, out_last));
      end else begin
        want = want_q.pop_front();
        if (out_status !== want.status || out_address_out !== want.addr ||
            out_word_out !== want.word || out_last !== want.last)
          log_error($sformatf({"result mismatch (exp/act): status %0d/%0d addr %0d/%0d ",
                               "word %h/%h last %0b/%0b"},
                              want.status, out_status, want.addr, out_address_out,
                              want.word, out_word_out, want.last, out_last));
      end
    end
  end

  // Watchdog: a run that stops moving in either direction is a failure
  int stall_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("ascii_word_machine_executor_top_tb failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    clear_machine();
    pm_get_base = -1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    sender_idle_pct = 30;
    test_reset_and_bounds();
    test_block_program();
    test_halt_and_init();
    wait_all_results();

    sender_idle_pct = 17;
    test_random_jobs(80);
    wait_all_results();
    sender_idle_pct = 85;
    test_random_jobs(80);
    wait_all_results();
    sender_idle_pct = 0;
    test_random_jobs(80);

    start <= 1'b0;
    while (want_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d commands, %0d results: %0d PD words, %0d GD requests, %0d halts,",
             n_sent, n_results, n_put, n_get, n_halt);
    $display("%0d bad-address results; %0d mismatches", n_bad, errors);
    if (errors == 0 && want_q.size() == 0) begin
      $display("ascii_word_machine_executor_top_tb passed");
    end else begin
      $display("ascii_word_machine_executor_top_tb failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/awme_pkg.sv
rtl/core/ascii_word_machine_executor_top.sv
test/ascii_word_machine_executor_top_tb.sv
